@@ hw/rtl/spd_pkg.sv @@
// Shared types, constants and the CRC byte update for the status packet deframer.
package spd_pkg;

  localparam int unsigned MaxBytes = 64;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  localparam logic [15:0] TimeoutReset = 16'd1000;
  localparam logic [15:0] CrcPoly      = 16'h8005;
  localparam logic [7:0]  InstrStatus  = 8'h55;

  localparam logic [1:0] OpByte  = 2'd0;
  localparam logic [1:0] OpTick  = 2'd1;
  localparam logic [1:0] OpStart = 2'd2;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StNoHeader  = 3'd1;
  localparam logic [2:0] StHdrTmo    = 3'd2;
  localparam logic [2:0] StIncomp    = 3'd3;
  localparam logic [2:0] StBadInstr  = 3'd4;
  localparam logic [2:0] StCrcErr    = 3'd5;
  localparam logic [2:0] StShortLen  = 3'd6;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [5:0]  param_count;
    logic [31:0] data_word;
    logic [7:0]  device_error;
    logic [2:0]  status;
  } result_t;

  // CRC-16, poly 0x8005, MSB first, one byte per call
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  localparam logic [15:0] HdrCrc =
    crc_feed(crc_feed(crc_feed(crc_feed(16'h0000, 8'hFF), 8'hFF), 8'hFD), 8'h00);

endpackage

@@ hw/rtl/spd_in_reg.sv @@
// Input register stage: holds one accepted transfer until the engine takes it.
module spd_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spd_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_take_i,
  output spd_pkg::item_t out_item_o
);
  import spd_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o  = !valid_q || out_take_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

endmodule

@@ hw/rtl/spd_engine.sv @@
// Deframer state and per-item update: header hunt, length, body, CRC check, tick timeout, byte limit.
module spd_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i,
  input  logic             fire_i,
  input  spd_pkg::item_t   item_i,
  output logic             res_valid_o,
  output spd_pkg::result_t res_o
);
  import spd_pkg::*;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhHunt = 2'd1;
  localparam logic [1:0] PhExt  = 2'd2;
  localparam logic [1:0] PhBody = 2'd3;

  logic [15:0]     timeout_q;
  logic [1:0]      phase_q, phase_d;
  logic [23:0]     recent_q, recent_d;
  logic [CntW-1:0] bsince_q, bsince_d;
  logic [CntW-1:0] bip_q, bip_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      instr_q, instr_d;
  logic [7:0]      err_q, err_d;
  logic [31:0]     param_q, param_d;
  logic [7:0]      crclo_q, crclo_d;
  logic [15:0]     tick_q, tick_d;

  logic [7:0]  b;
  logic [17:0] pos2;
  logic [17:0] len7;
  logic [15:0] crc_next;
  logic [15:0] got;
  logic [1:0]  pidx;
  logic        done;

  function automatic logic [2:0] fail_code(logic [1:0] ph);
    logic [2:0] st;
    case (ph)
      PhHunt:  st = StNoHeader;
      PhExt:   st = StHdrTmo;
      default: st = StIncomp;
    endcase
    return st;
  endfunction

  assign b        = item_i.rx_byte;
  assign crc_next = crc_feed(crc_q, b);
  assign pos2     = {{(18 - CntW){1'b0}}, bip_q} + 18'd2;
  assign len7     = {2'b00, len_q} + 18'd7;
  assign got      = {b, crclo_q};
  assign pidx     = bip_q[1:0] - 2'd1;

  always_comb begin
    phase_d     = phase_q;
    recent_d    = recent_q;
    bsince_d    = bsince_q;
    bip_d       = bip_q;
    len_d       = len_q;
    crc_d       = crc_q;
    instr_d     = instr_q;
    err_d       = err_q;
    param_d     = param_q;
    crclo_d     = crclo_q;
    tick_d      = tick_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    done        = 1'b0;

    if (fire_i) begin
      case (item_i.opcode)
        OpStart: begin
          phase_d  = PhHunt;
          recent_d = '0;
          bsince_d = '0;
          bip_d    = '0;
          len_d    = '0;
          crc_d    = '0;
          instr_d  = '0;
          err_d    = '0;
          param_d  = '0;
          crclo_d  = '0;
          tick_d   = '0;
        end
        OpTick: begin
          if (phase_q != PhIdle) begin
            if (tick_q != 16'hFFFF) begin
              tick_d = tick_q + 16'd1;
            end
            if (tick_d >= timeout_q) begin
              res_valid_o  = 1'b1;
              res_o.status = fail_code(phase_q);
              phase_d      = PhIdle;
            end
          end
        end
        OpByte: begin
          if (phase_q != PhIdle) begin
            bsince_d = bsince_q + 1'b1;
            case (phase_q)
              PhHunt: begin
                if (recent_q == 24'hFFFFFD && b == 8'h00) begin
                  crc_d   = HdrCrc;
                  bip_d   = CntW'(4);
                  phase_d = PhExt;
                end else begin
                  recent_d = {recent_q[15:0], b};
                end
              end
              PhExt: begin
                crc_d = crc_next;
                if (bip_q == CntW'(5)) begin
                  len_d = {8'h00, b};
                end else if (bip_q == CntW'(6)) begin
                  len_d = {b, len_q[7:0]};
                end
                bip_d = bip_q + 1'b1;
                if (bip_d >= CntW'(7)) begin
                  if (len_d < 16'd4) begin
                    res_valid_o  = 1'b1;
                    res_o.status = StShortLen;
                    phase_d      = PhIdle;
                    done         = 1'b1;
                  end else begin
                    phase_d = PhBody;
                  end
                end
              end
              default: begin
                bip_d = bip_q + 1'b1;
                if (pos2 < len7) begin
                  crc_d = crc_next;
                  if (bip_q == CntW'(7)) begin
                    instr_d = b;
                  end else if (bip_q == CntW'(8)) begin
                    err_d = b;
                  end else if (bip_q >= CntW'(9) && bip_q < CntW'(13)) begin
                    param_d[pidx*8 +: 8] = param_q[pidx*8 +: 8] | b;
                  end
                end else if (pos2 == len7) begin
                  crclo_d = b;
                end else begin
                  // second CRC byte: packet complete
                  res_valid_o = 1'b1;
                  phase_d     = PhIdle;
                  done        = 1'b1;
                  if (instr_q != InstrStatus) begin
                    res_o.status = StBadInstr;
                  end else begin
                    res_o.status       = (got != crc_q) ? StCrcErr : StOk;
                    res_o.device_error = err_q;
                    res_o.data_word    = param_q;
                    res_o.param_count  = 6'(len_q - 16'd4);
                  end
                end
              end
            endcase
            if (!done && bsince_d >= CntW'(MaxBytes)) begin
              res_valid_o  = 1'b1;
              res_o        = '0;
              res_o.status = fail_code(phase_d);
              phase_d      = PhIdle;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
      phase_q   <= PhIdle;
      recent_q  <= '0;
      bsince_q  <= '0;
      bip_q     <= '0;
      len_q     <= '0;
      crc_q     <= '0;
      instr_q   <= '0;
      err_q     <= '0;
      param_q   <= '0;
      crclo_q   <= '0;
      tick_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      phase_q  <= phase_d;
      recent_q <= recent_d;
      bsince_q <= bsince_d;
      bip_q    <= bip_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      instr_q  <= instr_d;
      err_q    <= err_d;
      param_q  <= param_d;
      crclo_q  <= crclo_d;
      tick_q   <= tick_d;
    end
  end

endmodule

@@ hw/rtl/spd_out_reg.sv @@
// Result register: holds one result transfer until the receiver takes it.
module spd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             space_o,
  input  logic             res_valid_i,
  input  spd_pkg::result_t res_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output spd_pkg::result_t out_res_o
);
  import spd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    valid_d = valid_q;
    if (space_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ hw/rtl/status_packet_deframer_core.sv @@
// Top level of the status packet deframer.
//
// Slave stream: one transfer per item. tuser carries the opcode (0 byte,
// 1 timer tick, 2 start), tdata carries the received byte.
// Master stream: one transfer per finished receive attempt, tdata packs
// status, device error byte, first four parameter bytes and parameter count.
// Config: cfg_we_i writes cfg_wdata_i into the tick timeout (reset 1000);
// write only while the block is idle.
// Path: an item is registered in the input register on accept; the engine
// processes it combinationally once the output register has space, and its
// result is registered in the output register, which drives tvalid.
// Throughput: one item per cycle while the output register has space; the state
// update is a single pass through one CRC byte step and a few compares per item.
// Reset: state goes idle, both stream registers empty, timeout back to 1000.
// Bytes and ticks are ignored until a start item arrives.
// Stall: a pending result holds in the output register; the input register
// still takes one more item, then tready drops until the receiver drains.
module status_packet_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] status, [10:3] device_error, [42:11] data_word, [48:43] param_count
  output logic [55:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  import spd_pkg::*;

  item_t   in_item;
  item_t   st_item;
  logic    st_valid;
  logic    space;
  logic    fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.opcode  = s_axis_tuser_i;
  assign in_item.rx_byte = s_axis_tdata_i;
  assign fire            = st_valid && space;

  spd_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .out_valid_o (st_valid),
    .out_take_i  (fire),
    .out_item_o  (st_item)
  );

  spd_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (st_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  spd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .space_o     (space),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata_o = {7'b0, out_res};

endmodule
